[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pdfls_pkg.sv]
// ---------------------------------------------------------------------------
// pdfls_pkg
// Types and constants shared by the PDF literal string decoder.
// ---------------------------------------------------------------------------
package pdfls_pkg;

    localparam int DEFAULT_MAX_NEST_DEPTH = 255;
    localparam int OCTAL_DIGITS           = 3;
    localparam int RESULT_FIFO_DEPTH      = 4;

    // Byte codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG7   = 8'h37;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_CLOSED = 2'd1,
        ST_UNTERM = 2'd2,
        ST_DEEP   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_result;

    // Results made by one request: count is 0..2, r0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[design/pdfls_decode.sv]
// ---------------------------------------------------------------------------
// pdfls_decode
// Escape/octal/nesting state machine; makes up to two results per request.
// ---------------------------------------------------------------------------
module pdfls_decode #(
    parameter int MAX_NEST_DEPTH = pdfls_pkg::DEFAULT_MAX_NEST_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output pdfls_pkg::t_push  o_push
);
    import pdfls_pkg::*;

    localparam int              DepthW   = $clog2(MAX_NEST_DEPTH + 1);
    localparam logic [DepthW-1:0] MaxDepth = DepthW'(MAX_NEST_DEPTH);
    localparam logic [1:0]      LastDigit = 2'(OCTAL_DIGITS - 1);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } t_mode;

    t_mode             r_mode,    n_mode;
    logic [DepthW-1:0] r_depth,   n_depth;
    logic [7:0]        r_accum,   n_accum;
    logic [1:0]        r_digits,  n_digits;
    logic              r_drop_lf, n_drop_lf;

    function automatic t_result mk_data(input logic [7:0] d);
        t_result res;
        res.data   = d;
        res.status = ST_DATA;
        res.last   = 1'b0;
        return res;
    endfunction

    function automatic t_result mk_end(input t_status s);
        t_result res;
        res.data   = 8'h00;
        res.status = s;
        res.last   = 1'b1;
        return res;
    endfunction

    always_comb begin
        logic       run_nb;
        logic       pre_v;
        t_result    pre;
        logic       main_v;
        t_result    main;
        logic [7:0] oct_next;

        n_mode    = r_mode;
        n_depth   = r_depth;
        n_accum   = r_accum;
        n_digits  = r_digits;
        n_drop_lf = r_drop_lf;
        run_nb    = 1'b0;
        pre_v     = 1'b0;
        pre       = '0;
        main_v    = 1'b0;
        main      = '0;
        oct_next  = {r_accum[4:0], i_byte[2:0]};

        if (i_eoi) begin
            // flush a pending octal byte, then report unterminated
            pre_v     = (r_mode == MODE_OCTAL);
            pre       = mk_data(r_accum);
            main_v    = 1'b1;
            main      = mk_end(ST_UNTERM);
            n_mode    = MODE_NORMAL;
            n_depth   = '0;
            n_accum   = '0;
            n_digits  = '0;
            n_drop_lf = 1'b0;
        end else begin
            case (r_mode)
                MODE_ESCAPE: begin
                    n_mode = MODE_NORMAL;
                    case (i_byte)
                        CH_LC_N: begin main_v = 1'b1; main = mk_data(CH_LF);  end
                        CH_LC_R: begin main_v = 1'b1; main = mk_data(CH_CR);  end
                        CH_LC_T: begin main_v = 1'b1; main = mk_data(CH_TAB); end
                        CH_LC_B: begin main_v = 1'b1; main = mk_data(CH_BS);  end
                        CH_LC_F: begin main_v = 1'b1; main = mk_data(CH_FF);  end
                        CH_CR:   n_drop_lf = 1'b1;   // line continuation
                        CH_LF:   ;                    // line continuation
                        default: begin
                            if (i_byte inside {[CH_DIG0:CH_DIG7]}) begin
                                n_mode   = MODE_OCTAL;
                                n_accum  = {5'd0, i_byte[2:0]};
                                n_digits = 2'd1;
                            end else begin
                                // paren, backslash and unknown escapes pass the byte
                                main_v = 1'b1;
                                main   = mk_data(i_byte);
                            end
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (i_byte inside {[CH_DIG0:CH_DIG7]}) begin
                        if (r_digits == LastDigit) begin
                            main_v   = 1'b1;
                            main     = mk_data(oct_next);
                            n_mode   = MODE_NORMAL;
                            n_accum  = '0;
                            n_digits = '0;
                        end else begin
                            n_accum  = oct_next;
                            n_digits = r_digits + 2'd1;
                        end
                    end else begin
                        // cut short: flush, then treat the byte as text
                        pre_v    = 1'b1;
                        pre      = mk_data(r_accum);
                        n_mode   = MODE_NORMAL;
                        n_accum  = '0;
                        n_digits = '0;
                        run_nb   = 1'b1;
                    end
                end
                default: run_nb = 1'b1;
            endcase
        end

        if (run_nb) begin
            n_drop_lf = 1'b0;
            if (!(r_drop_lf && i_byte == CH_LF)) begin
                case (i_byte)
                    CH_LPAREN: begin
                        if (r_depth >= MaxDepth) begin
                            main_v   = 1'b1;
                            main     = mk_end(ST_DEEP);
                            n_mode   = MODE_NORMAL;
                            n_depth  = '0;
                            n_accum  = '0;
                            n_digits = '0;
                        end else begin
                            n_depth = r_depth + DepthW'(1);
                            main_v  = 1'b1;
                            main    = mk_data(i_byte);
                        end
                    end
                    CH_RPAREN: begin
                        if (r_depth == '0) begin
                            main_v   = 1'b1;
                            main     = mk_end(ST_CLOSED);
                            n_mode   = MODE_NORMAL;
                            n_depth  = '0;
                            n_accum  = '0;
                            n_digits = '0;
                        end else begin
                            n_depth = r_depth - DepthW'(1);
                            main_v  = 1'b1;
                            main    = mk_data(i_byte);
                        end
                    end
                    CH_BSLASH: n_mode = MODE_ESCAPE;
                    CH_CR: begin
                        n_drop_lf = 1'b1;
                        main_v    = 1'b1;
                        main      = mk_data(CH_LF);
                    end
                    default: begin
                        main_v = 1'b1;
                        main   = mk_data(i_byte);
                    end
                endcase
            end
        end

        if (pre_v) begin
            o_push.r0    = pre;
            o_push.r1    = main;
            o_push.count = main_v ? 2'd2 : 2'd1;
        end else begin
            o_push.r0    = main;
            o_push.r1    = '0;
            o_push.count = {1'b0, main_v};
        end
        if (!i_advance) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_depth   <= '0;
            r_accum   <= '0;
            r_digits  <= '0;
            r_drop_lf <= 1'b0;
        end else if (i_advance) begin
            r_mode    <= n_mode;
            r_depth   <= n_depth;
            r_accum   <= n_accum;
            r_digits  <= n_digits;
            r_drop_lf <= n_drop_lf;
        end
    end

endmodule

[design/pdfls_result_fifo.sv]
// ---------------------------------------------------------------------------
// pdfls_result_fifo
// Small result queue: takes up to two results a cycle, gives out one.
// ---------------------------------------------------------------------------
module pdfls_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdfls_pkg::t_push    i_push,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_valid,
    output pdfls_pkg::t_result  o_head
);
    import pdfls_pkg::*;

    localparam int PtrW = $clog2(RESULT_FIFO_DEPTH);
    localparam int CntW = $clog2(RESULT_FIFO_DEPTH + 1);

    t_result         r_mem [RESULT_FIFO_DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_count, n_count;

    // room for a full two-result request
    assign o_room  = (r_count <= CntW'(RESULT_FIFO_DEPTH - 2)) ||
                     ((r_count == CntW'(RESULT_FIFO_DEPTH - 1)) && i_pop);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign n_count = r_count + CntW'(i_push.count) - CntW'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PtrW'(i_push.count);
            r_rd    <= r_rd + PtrW'(i_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PtrW'(1)] <= i_push.r1;
        end
    end

endmodule

[design/pdf_literal_string_decoder_core.sv]
// An accepted byte is held in the input register, decoded, and its results
// go to the result queue that drives m_axis. Throughput: one byte per cycle
// while the queue has room; the m_axis side takes one result per cycle, and a
// cut-short octal escape gives two. Backslash or continuation bytes give none.
// Reset (i_rst_n low, synchronous) clears decode state and empties the queue.
// ---------------------------------------------------------------------------
// pdf_literal_string_decoder_core
// Decodes a PDF literal string body into bytes plus an end status.
// ---------------------------------------------------------------------------
module pdf_literal_string_decoder_core #(
    parameter int MAX_NEST_DEPTH = pdfls_pkg::DEFAULT_MAX_NEST_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,   // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast    // last result of a string
);
    import pdfls_pkg::*;

    // Input register: one request waits here until the queue has room for
    // two results, so it never has to split its output.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    logic    w_room;
    logic    w_advance;
    logic    w_pop;
    t_push   w_push;
    t_result w_head;

    assign w_advance     = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_pop         = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser[0];
        end
    end

    // Decode state machine: all per-byte work is one combinational pass.
    pdfls_decode #(
        .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_eoi     (r_in_eoi),
        .o_push    (w_push)
    );

    // Result queue doubles as the output register toward m_axis.
    pdfls_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head)
    );

    assign m_axis_tdata = w_head.data;
    assign m_axis_tuser = w_head.status;
    assign m_axis_tlast = w_head.last;

endmodule

[design/pdfls_checker.sv]
// ---------------------------------------------------------------------------
// pdfls_checker
// Port-level checks for the literal string decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdfls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import pdfls_pkg::*;

    logic w_is_end;
    logic w_in_seen;

    assign w_is_end  = (m_axis_tuser != 2'(ST_DATA));
    assign w_in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata) &&
                       (s_axis_tuser == s_axis_tuser);

    // tlast marks exactly the end results
    `ASSERT_CLK(a_last_on_end, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tlast == w_is_end), "tlast does not match end status")

    // end results carry a zero byte
    `ASSERT_CLK(a_end_zero, i_clk, i_rst_n, (m_axis_tvalid && w_is_end) |-> (m_axis_tdata == 8'h00), "end result with nonzero data")

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "stalled result changed")

    // reset empties the queue and opens the input
    `ASSERT_ANY(a_reset_clean, i_clk, (!i_rst_n || (w_in_seen && !i_rst_n)) |=> (!m_axis_tvalid && s_axis_tready), "not idle after reset")

endmodule

bind pdf_literal_string_decoder_core pdfls_checker u_pdfls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for pdf_literal_string_decoder_core. Raw string body
// bytes go in on s_axis; an in-bench decoder predicts every result, and each
// result leaving m_axis is compared against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
    import pdfls_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int NEST_LIMIT   = DEFAULT_MAX_NEST_DEPTH;
    localparam int RANDOM_ITEMS = 1030;
    localparam int IDLE_PCT     = 22;    // idle cycles per hundred, each side
    localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 20;    // settling time after the last predicted result
    localparam int STALL_LIMIT  = 2000;  // cycles with nothing moving on either side

    // Decoder modes of the predictor
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_OCT  = 2'd2
    } t_mode;

    // -----------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // -----------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic [0:0] s_axis_tuser  = 1'b0;   // [0] end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [1:0] m_axis_tuser;           // [1:0] status
    logic       m_axis_tlast;

    pdf_literal_string_decoder_core #(
        .MAX_NEST_DEPTH(NEST_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the decoder state
    // -----------------------------------------------------------------------
    int unsigned nest_lvl;
    t_mode       dec_mode;
    logic [7:0]  oct_val;
    logic [1:0]  oct_cnt;
    logic        skip_lf;   // CR just consumed, a following LF is swallowed

    t_result     decoded_q[$];  // predicted results, oldest first

    // Run bookkeeping
    int n_sent     = 0;
    int n_results  = 0;
    int n_ends     = 0;
    int n_closed   = 0;
    int n_unterm   = 0;
    int n_deep     = 0;
    int n_in_stall = 0;
    int errors     = 0;

    // Idle control shared by both sides; hold-off control for the receiver
    bit idle_en     = 1'b1;
    int hold_ticket = 0;   // bumped by a test to ask for a long hold-off
    int hold_served = 0;
    int hold_left   = 0;

    function automatic void clear_decoder();
        nest_lvl = 0;
        dec_mode = MODE_TEXT;
        oct_val  = 8'h00;
        oct_cnt  = 2'd0;
        skip_lf  = 1'b0;
    endfunction

    // Queue one predicted result. Any end status also wipes the string state.
    function automatic void push_result(input logic [7:0] d, input t_status st);
        t_result r;
        r.data   = d;
        r.status = st;
        r.last   = (st != ST_DATA);
        decoded_q.push_back(r);
        if (st != ST_DATA) begin
            n_ends++;
            case (st)
                ST_CLOSED: n_closed++;
                ST_UNTERM: n_unterm++;
                default:   n_deep++;
            endcase
            clear_decoder();
        end
    endfunction

    // Plain text byte: nesting, backslash entry, CR folding.
    function automatic void decode_text(input logic [7:0] c);
        if (skip_lf) begin
            skip_lf = 1'b0;
            if (c == CH_LF)
                return;
        end
        case (c)
            CH_LPAREN: begin
                if (nest_lvl >= NEST_LIMIT) begin
                    push_result(8'h00, ST_DEEP);
                end else begin
                    nest_lvl++;
                    push_result(c, ST_DATA);
                end
            end
            CH_RPAREN: begin
                if (nest_lvl == 0) begin
                    push_result(8'h00, ST_CLOSED);
                end else begin
                    nest_lvl--;
                    push_result(c, ST_DATA);
                end
            end
            CH_BSLASH: dec_mode = MODE_ESC;
            CH_CR: begin
                skip_lf = 1'b1;
                push_result(CH_LF, ST_DATA);
            end
            default: push_result(c, ST_DATA);
        endcase
    endfunction

    // Expected results for one accepted input request.
    function automatic void predict_request(input logic [7:0] c, input logic eoi);
        if (eoi) begin
            // pending octal byte goes out first; a lone backslash is dropped
            if (dec_mode == MODE_OCT)
                push_result(oct_val, ST_DATA);
            push_result(8'h00, ST_UNTERM);
            return;
        end
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_TEXT;
                case (c)
                    CH_LC_N: push_result(CH_LF, ST_DATA);
                    CH_LC_R: push_result(CH_CR, ST_DATA);
                    CH_LC_T: push_result(CH_TAB, ST_DATA);
                    CH_LC_B: push_result(CH_BS, ST_DATA);
                    CH_LC_F: push_result(CH_FF, ST_DATA);
                    CH_LPAREN, CH_RPAREN, CH_BSLASH: push_result(c, ST_DATA);
                    CH_CR: skip_lf = 1'b1;     // continuation, maybe CR LF
                    CH_LF: ;                   // continuation
                    default: begin
                        if (c >= CH_DIG0 && c <= CH_DIG7) begin
                            dec_mode = MODE_OCT;
                            oct_val  = c - CH_DIG0;
                            oct_cnt  = 2'd1;
                        end else begin
                            push_result(c, ST_DATA);   // unknown escape
                        end
                    end
                endcase
            end
            MODE_OCT: begin
                if (c >= CH_DIG0 && c <= CH_DIG7) begin
                    // bits shifted past bit 7 are lost
                    oct_val = {oct_val[4:0], c[2:0]};
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt >= OCTAL_DIGITS) begin
                        push_result(oct_val, ST_DATA);
                        dec_mode = MODE_TEXT;
                        oct_val  = 8'h00;
                        oct_cnt  = 2'd0;
                    end
                end else begin
                    // cut short: flush the octal byte, then treat c as text
                    push_result(oct_val, ST_DATA);
                    dec_mode = MODE_TEXT;
                    oct_val  = 8'h00;
                    oct_cnt  = 2'd0;
                    decode_text(c);
                end
            end
            default: decode_text(c);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Sender: one input request, optional idle gap in front of it
    // -----------------------------------------------------------------------
    task automatic send_request(input logic [7:0] b, input logic eoi);
        if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (idle_en && $urandom_range(0, 99) < IDLE_PCT)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_request(b, eoi);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0);
    endtask

    // -----------------------------------------------------------------------
    // Receiver: random ready, plus long hold-offs on request
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_ticket != hold_served) begin
            hold_served   <= hold_ticket;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: data=%02h status=%0d last=%0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data) begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_axis_tdata);
                end
                if (m_axis_tuser !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: ends the run if neither a request nor a result moves for too long
    // -----------------------------------------------------------------------
    int stall_cnt = 0;

    always @(posedge i_clk) begin
        if (s_axis_tvalid && !s_axis_tready && i_rst_n)
            n_in_stall++;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, decoded_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // All named escapes, unknown escapes (digit 9 too), then close.
    task automatic test_escapes();
        send_text("\\n\\r\\t\\b\\f\\(\\)\\\\\\q\\9)");
    endtask

    // Three digits, cut short by text, overflow, cut short by the close,
    // and an octal byte still pending when the stream ends.
    task automatic test_octal();
        send_text("\\101\\7x\\777\\0123\\5)");
        send_text("\\12");
        send_request(8'hFF, 1'b1);
    endtask

    // Bare CR, CR LF, CR CR LF, all three continuations, extreme bytes.
    task automatic test_line_ends();
        send_text("a");
        send_request(CH_CR, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_LF, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_CR, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text(")");
    endtask

    // Empty unterminated string, and a lone backslash at the end.
    task automatic test_end_of_input();
        send_request(8'h00, 1'b1);
        send_text("x\\");
        send_request(8'h00, 1'b1);
    endtask

    // Inner parens kept as data, escaped paren not counted.
    task automatic test_nesting();
        send_text("(a(\\)b))c)");
    endtask

    // Walk up to the depth bound, step back, and go one past it.
    task automatic test_deep_nesting();
        repeat (NEST_LIMIT) send_request(CH_LPAREN, 1'b0);
        send_request(CH_RPAREN, 1'b0);
        send_request(CH_LPAREN, 1'b0);
        send_request(CH_LPAREN, 1'b0);   // too deep
    endtask

    // Receiver stalls for a long stretch while input keeps coming, so the
    // result queue fills and the block has to drop s_axis_tready.
    task automatic test_backpressure();
        hold_ticket++;
        repeat (40) send_request(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
        send_request(CH_RPAREN, 1'b0);
    endtask

    // Mostly well-formed strings with random content; some noise bytes,
    // stray closes and strings that run into the next one.
    task automatic test_random();
        int stop_at;
        int parts;
        int ends_at_start;
        int r;
        stop_at = n_sent + RANDOM_ITEMS;
        while (n_sent < stop_at) begin
            // a stretch with no idling on either side
            idle_en = !(n_sent > stop_at - 900 && n_sent < stop_at - 600);
            parts = $urandom_range(1, 12);
            repeat (parts) begin
                case ($urandom_range(0, 11))
                    0, 1: send_request(8'($urandom_range(0, 255)), 1'b0);
                    2:    send_request(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                    3: begin
                        send_request(CH_BSLASH, 1'b0);
                        case ($urandom_range(0, 7))
                            0: send_request(CH_LC_N, 1'b0);
                            1: send_request(CH_LC_R, 1'b0);
                            2: send_request(CH_LC_T, 1'b0);
                            3: send_request(CH_LC_B, 1'b0);
                            4: send_request(CH_LC_F, 1'b0);
                            5: send_request(CH_LPAREN, 1'b0);
                            6: send_request(CH_RPAREN, 1'b0);
                            default: send_request(CH_BSLASH, 1'b0);
                        endcase
                    end
                    4: begin
                        send_request(CH_BSLASH, 1'b0);
                        send_request(8'($urandom_range(0, 255)), 1'b0);
                    end
                    5: begin
                        send_request(CH_BSLASH, 1'b0);
                        repeat ($urandom_range(1, 3))
                            send_request(CH_DIG0 + 8'($urandom_range(0, 7)), 1'b0);
                    end
                    6: send_request(CH_LPAREN, 1'b0);
                    7: begin
                        if (nest_lvl > 0)
                            send_request(CH_RPAREN, 1'b0);
                        else
                            send_request(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                    end
                    8: begin
                        send_request(CH_CR, 1'b0);
                        if ($urandom_range(0, 1))
                            send_request(CH_LF, 1'b0);
                    end
                    9: begin
                        send_request(CH_BSLASH, 1'b0);
                        r = $urandom_range(0, 2);
                        if (r != 1)
                            send_request(CH_CR, 1'b0);
                        if (r != 0)
                            send_request(CH_LF, 1'b0);
                    end
                    10: send_request(CH_DIG0 + 8'($urandom_range(0, 9)), 1'b0);
                    default: send_request(CH_LF, 1'b0);
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // close until the string actually ends
                ends_at_start = n_ends;
                while (n_ends == ends_at_start)
                    send_request(CH_RPAREN, 1'b0);
            end else if (r < 92) begin
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        idle_en = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        clear_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_escapes();
        test_octal();
        test_line_ends();
        test_end_of_input();
        test_nesting();
        test_deep_nesting();
        test_backpressure();
        test_random();

        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input requests and %0d checked results.",
                 n_sent, n_results);
        $display("Strings: %0d closed, %0d unterminated, %0d too deep; input stalled %0d cycles.",
                 n_closed, n_unterm, n_deep, n_in_stall);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
